@@ rtl/atsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsd_pkg: shared types and constants of the TCP stream deframer
// Result record, byte kinds, status codes, preamble table, queue sizing.
// ----------------------------------------------------------------------------
package atsd_pkg;

  // Fixed 16-byte stream preamble, first byte at index 0
  localparam logic [7:0] PREAMBLE [16] = '{
    8'h00, 8'h14, 8'h00, 8'h00,
    8'h41, 8'h53, 8'h43, 8'h2d,
    8'h45, 8'h31, 8'h2e, 8'h31,
    8'h37, 8'h00, 8'h00, 8'h00
  };

  localparam int PREAMBLE_LEN  = 16;
  localparam int SIZE_END      = 20;  // byte count after the last block size byte

  // Result queue between classifier and output stage (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 7;

  typedef enum logic [1:0] {
    KIND_PREAMBLE,
    KIND_SIZE,
    KIND_PDU
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_PREAMBLE,
    ST_SHORT_LEN,
    ST_OVERRUN,
    ST_DEAD
  } status_t;

  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    logic        pdu_first;
    logic        pdu_last;
    logic        block_last;
    logic [19:0] pdu_length;
    status_t     status;
  } result_t;

endpackage

@@ rtl/acn_tcp_stream_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_tcp_stream_deframer: ACN TCP stream preamble / PDU block deframer
// Path: an accepted byte is written into the result queue, then loaded into the
//   output register once that is free. Throughput: one byte per cycle while the
//   queue has room, bounded by the classifier state update (20-bit count compare and 32-bit block consumed compare).
// Reset: synchronous, active low; clears framing state, queue and output
//   valid. No clearing pass, the block takes bytes right after reset.
// ----------------------------------------------------------------------------
module acn_tcp_stream_deframer (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input byte stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] in_byte
  // Tagged byte stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [atsd_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] out_byte,
                                                        // [27:8] pdu_length,
                                                        // [31:28] zero
  output logic [atsd_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [1:0] byte_kind,
                                                        // [2] pdu_first,
                                                        // [3] pdu_last,
                                                        // [6:4] status
  output logic                              out_tlast   // block_last
);

  // Front: classify each request and push its result into the queue
  logic               push;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  atsd_pkg::result_t  res;
  atsd_pkg::result_t  q_data;

  // Accept whenever the queue has room; the output side drains it
  // independently, so a stalled consumer only backs up after the queue fills.
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  atsd_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (push),
    .byte_in (in_tdata),
    .res     (res)
  );

  // Short queue between front and back
  atsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Back: output register and packing onto the stream ports
  atsd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Once an error is reported, the very next request is reported dead
  a_error_latches: assert property (@(posedge clk) disable iff (!rst_n)
    push && (res.status == atsd_pkg::ST_BAD_PREAMBLE ||
             res.status == atsd_pkg::ST_SHORT_LEN ||
             res.status == atsd_pkg::ST_OVERRUN)
    |=> !push || res.status == atsd_pkg::ST_DEAD)
    else $error("deframer error did not latch the stream dead");

  // Block end always closes a PDU
  a_block_last_pdu: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.block_last |-> res.pdu_last && res.kind == atsd_pkg::KIND_PDU)
    else $error("block_last without pdu_last on a PDU byte");

  // Flags byte carries no decoded length yet
  a_first_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.pdu_first |-> res.kind == atsd_pkg::KIND_PDU && res.pdu_length == '0)
    else $error("pdu_first on a byte with a decoded length");

  // Queue never pops while empty nor takes a request while full
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty) && !(push && q_full))
    else $error("result queue overflow or underflow");

endmodule

@@ rtl/atsd_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsd_classify: front end of the deframer
// Track preamble, block size and PDU framing; tag each accepted byte.
// ----------------------------------------------------------------------------
module atsd_classify (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         byte_in,
  output atsd_pkg::result_t  res
);

  typedef enum logic [1:0] {
    PH_PREAMBLE,
    PH_SIZE,
    PH_HEADER,
    PH_BODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [19:0] cnt_r, cnt_nxt;
  logic [31:0] bsize_r, bsize_nxt;
  logic [31:0] bcons_r, bcons_nxt;
  logic [19:0] psize_r, psize_nxt;
  logic        long_r, long_nxt;
  logic        alive_r, alive_nxt;

  logic [19:0] cnt_inc;
  logic [31:0] cons_inc;
  logic        cons_hit;
  logic [19:0] len_bytes;
  logic        pdu_done;
  logic        chk;

  assign cnt_inc   = cnt_r + 20'd1;
  assign cons_inc  = bcons_r + 32'd1;
  assign cons_hit  = (cons_inc == bsize_r);
  assign len_bytes = long_r ? 20'd3 : 20'd2;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bsize_nxt = bsize_r;
    bcons_nxt = bcons_r;
    psize_nxt = psize_r;
    long_nxt  = long_r;
    alive_nxt = alive_r;
    pdu_done  = 1'b0;
    chk       = 1'b0;
    res            = '0;
    res.data       = byte_in;
    res.kind       = atsd_pkg::KIND_PREAMBLE;
    res.status     = atsd_pkg::ST_OK;

    if (!alive_r) begin
      res.status = atsd_pkg::ST_DEAD;
    end else begin
      case (phase_r)
        PH_SIZE: begin
          res.kind  = atsd_pkg::KIND_SIZE;
          bsize_nxt = {bsize_r[23:0], byte_in};
          cnt_nxt   = cnt_inc;
          if (cnt_inc >= 20'(atsd_pkg::SIZE_END)) begin
            cnt_nxt = '0;
            if (bsize_nxt == '0) begin
              phase_nxt = PH_PREAMBLE;
            end else begin
              bcons_nxt = '0;
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          res.kind  = atsd_pkg::KIND_PDU;
          bcons_nxt = cons_inc;
          if (cnt_r == '0) begin
            res.pdu_first = 1'b1;
            long_nxt      = byte_in[7];
            psize_nxt     = {16'd0, byte_in[3:0]};
            cnt_nxt       = 20'd1;
            chk           = 1'b1;
          end else begin
            psize_nxt = {psize_r[11:0], byte_in};
            cnt_nxt   = cnt_inc;
            if (cnt_inc >= len_bytes) begin
              res.pdu_length = psize_nxt;
              if (psize_nxt < len_bytes) begin
                res.status = atsd_pkg::ST_SHORT_LEN;
                alive_nxt  = 1'b0;
              end else if (psize_nxt == cnt_inc) begin
                pdu_done = 1'b1;
              end else begin
                phase_nxt = PH_BODY;
                chk       = 1'b1;
              end
            end else begin
              chk = 1'b1;
            end
          end
        end
        PH_BODY: begin
          res.kind       = atsd_pkg::KIND_PDU;
          res.pdu_length = psize_r;
          bcons_nxt      = cons_inc;
          cnt_nxt        = cnt_inc;
          if (cnt_inc == psize_r) begin
            pdu_done = 1'b1;
          end else begin
            chk = 1'b1;
          end
        end
        default: begin
          if (byte_in != atsd_pkg::PREAMBLE[cnt_r[3:0]]) begin
            res.status = atsd_pkg::ST_BAD_PREAMBLE;
            alive_nxt  = 1'b0;
          end else begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= 20'(atsd_pkg::PREAMBLE_LEN)) begin
              phase_nxt = PH_SIZE;
              bsize_nxt = '0;
            end
          end
        end
      endcase

      // Block filled while the PDU is still open
      if (chk && cons_hit) begin
        res.status = atsd_pkg::ST_OVERRUN;
        alive_nxt  = 1'b0;
      end

      if (pdu_done) begin
        res.pdu_last = 1'b1;
        cnt_nxt      = '0;
        if (cons_hit) begin
          res.block_last = 1'b1;
          phase_nxt      = PH_PREAMBLE;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREAMBLE;
      cnt_r   <= '0;
      bsize_r <= '0;
      bcons_r <= '0;
      psize_r <= '0;
      long_r  <= 1'b0;
      alive_r <= 1'b1;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bsize_r <= bsize_nxt;
      bcons_r <= bcons_nxt;
      psize_r <= psize_nxt;
      long_r  <= long_nxt;
      alive_r <= alive_nxt;
    end
  end

endmodule

@@ rtl/atsd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsd_queue: short result queue
// Decouple the classifier from the output stage so each stalls on its own.
// ----------------------------------------------------------------------------
module atsd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  atsd_pkg::result_t  push_data,
  output logic               full,
  input  logic               pop,
  output atsd_pkg::result_t  pop_data,
  output logic               empty
);

  atsd_pkg::result_t                  mem_r [atsd_pkg::QUEUE_DEPTH];
  logic [atsd_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [atsd_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [atsd_pkg::QCNT_W-1:0]        count_r, count_nxt;

  assign full     = (count_r == atsd_pkg::QCNT_W'(atsd_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/atsd_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsd_emit: back end of the deframer
// Pull results from the queue into the output register and pack the stream.
// ----------------------------------------------------------------------------
module atsd_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  atsd_pkg::result_t                   q_data,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [atsd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [atsd_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast
);

  logic              valid_r;
  atsd_pkg::result_t hold_r;

  // Load whenever the register is empty or its request is being taken
  assign q_pop = !q_empty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold_r <= q_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, hold_r.pdu_length, hold_r.data};
  assign out_tuser  = {hold_r.status, hold_r.pdu_last, hold_r.pdu_first, hold_r.kind};
  assign out_tlast  = hold_r.block_last;

endmodule
